### src/utf8_sanitizer_latin1_fallback_assert.svh
// assertion macros used by the sanitizer checker
`ifndef UTF8_SANITIZER_LATIN1_FALLBACK_ASSERT_SVH
`define UTF8_SANITIZER_LATIN1_FALLBACK_ASSERT_SVH

// same-cycle implication
`define U8S_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8s assertion failed");

// next-cycle implication
`define U8S_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8s assertion failed");

`endif

### src/u8s_pkg.sv
// shared types, constants and helpers of the utf-8 sanitizer
package u8s_pkg;

   localparam int ByteW      = 8;
   localparam int MaxOut     = 8;
   localparam int CountW     = 4;
   localparam int OutIdxW    = 3;
   localparam int PendDepth  = 3;
   localparam int PendW      = 2;
   localparam int LenW       = 3;
   localparam int QueueDepth = 4;
   localparam int QPtrW      = 2;
   localparam int QCntW      = 3;

   // lead byte ranges
   localparam logic [ByteW-1:0] LeadLo  = 8'hC2;
   localparam logic [ByteW-1:0] LeadHi  = 8'hF4;
   localparam logic [ByteW-1:0] Lead2Hi = 8'hDF;
   localparam logic [ByteW-1:0] Lead3Hi = 8'hEF;

   // continuation bounds, general and after the restricted leads
   localparam logic [ByteW-1:0] ContLo  = 8'h80;
   localparam logic [ByteW-1:0] ContHi  = 8'hBF;
   localparam logic [ByteW-1:0] LeadE0  = 8'hE0;
   localparam logic [ByteW-1:0] LeadED  = 8'hED;
   localparam logic [ByteW-1:0] LeadF0  = 8'hF0;
   localparam logic [ByteW-1:0] LeadF4  = 8'hF4;
   localparam logic [ByteW-1:0] LoE0    = 8'hA0;
   localparam logic [ByteW-1:0] HiED    = 8'h9F;
   localparam logic [ByteW-1:0] LoF0    = 8'h90;
   localparam logic [ByteW-1:0] HiF4    = 8'h8F;

   // sequence lengths
   localparam logic [LenW-1:0] Len2 = 3'd2;
   localparam logic [LenW-1:0] Len3 = 3'd3;
   localparam logic [LenW-1:0] Len4 = 3'd4;

   // output bytes caused by one input byte
   typedef struct packed {
      logic [MaxOut-1:0][ByteW-1:0] out_bytes;
      logic [CountW-1:0]            count;
   } entry_type;

   // first byte of the two-byte latin-1 form (c2 or c3)
   function automatic logic [ByteW-1:0] latin1_lead(input logic [ByteW-1:0] b);
      return {7'b1100001, b[6]};
   endfunction

   // second byte of the two-byte latin-1 form
   function automatic logic [ByteW-1:0] latin1_tail(input logic [ByteW-1:0] b);
      return {2'b10, b[5:0]};
   endfunction

endpackage

### src/u8s_ifs.sv
// valid/ready channel interfaces of the sanitizer

// raw byte channel
interface u8s_req_if;
   logic                       valid;
   logic                       ready;
   logic [u8s_pkg::ByteW-1:0]  data_byte;
   logic                       end_of_stream;

   modport source(output valid, output data_byte, output end_of_stream, input ready);
   modport sink(input valid, input data_byte, input end_of_stream, output ready);
endinterface

// cleaned byte channel
interface u8s_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [u8s_pkg::ByteW-1:0]  out_byte;
   logic                       last_of_run;

   modport source(output valid, output out_byte, output last_of_run, input ready);
   modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

### src/u8s_front.sv
// front end: tracks the pending sequence and builds the output bytes of each input byte
module u8s_front (
   input  logic               clock,
   input  logic               reset,
   u8s_req_if.sink            req_if,
   input  logic               q_full,
   output logic               push,
   output u8s_pkg::entry_type push_entry
);

   logic [u8s_pkg::ByteW-1:0] pend_ff [u8s_pkg::PendDepth];
   logic [u8s_pkg::ByteW-1:0] pend_in [u8s_pkg::PendDepth];
   logic [u8s_pkg::PendW-1:0] cnt_ff, cnt_in;
   logic [u8s_pkg::LenW-1:0]  exp_ff, exp_in;
   logic                      cont_ok;
   logic                      xfer;
   logic [u8s_pkg::MaxOut-1:0][u8s_pkg::ByteW-1:0] obuf;
   logic [u8s_pkg::CountW-1:0] n;

   assign req_if.ready = !q_full;
   assign xfer         = req_if.valid && req_if.ready;

   // continuation range, narrowed after e0, ed, f0 and f4
   always_comb begin
      logic [u8s_pkg::ByteW-1:0] lo;
      logic [u8s_pkg::ByteW-1:0] hi;
      lo = u8s_pkg::ContLo;
      hi = u8s_pkg::ContHi;
      if (cnt_ff == 2'd1) begin
         case (pend_ff[0])
            u8s_pkg::LeadE0: lo = u8s_pkg::LoE0;
            u8s_pkg::LeadED: hi = u8s_pkg::HiED;
            u8s_pkg::LeadF0: lo = u8s_pkg::LoF0;
            u8s_pkg::LeadF4: hi = u8s_pkg::HiF4;
            default: ;
         endcase
      end
      cont_ok = (req_if.data_byte >= lo) && (req_if.data_byte <= hi);
   end

   // classify the byte, build its output bytes and the next pending state
   always_comb begin
      logic [u8s_pkg::ByteW-1:0] b;
      logic                      fresh;
      b       = req_if.data_byte;
      fresh   = 1'b0;
      obuf    = '0;
      n       = '0;
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      exp_in  = exp_ff;

      if (cnt_ff == '0) begin
         fresh = 1'b1;
      end else if (cont_ok) begin
         if (({1'b0, cnt_ff} + 3'd1) >= exp_ff) begin
            // sequence complete: pass it through
            for (int i = 0; i < u8s_pkg::PendDepth; i++) begin
               if (u8s_pkg::PendW'(i) < cnt_ff) begin
                  obuf[n[u8s_pkg::OutIdxW-1:0]] = pend_ff[i];
                  n = n + 4'd1;
               end
            end
            obuf[n[u8s_pkg::OutIdxW-1:0]] = b;
            n      = n + 4'd1;
            cnt_in = '0;
            exp_in = '0;
         end else begin
            pend_in[cnt_ff] = b;
            cnt_in          = cnt_ff + 2'd1;
         end
      end else begin
         // bad continuation: held bytes go out as latin-1
         for (int i = 0; i < u8s_pkg::PendDepth; i++) begin
            if (u8s_pkg::PendW'(i) < cnt_ff) begin
               obuf[n[u8s_pkg::OutIdxW-1:0]] = u8s_pkg::latin1_lead(pend_ff[i]);
               n = n + 4'd1;
               obuf[n[u8s_pkg::OutIdxW-1:0]] = u8s_pkg::latin1_tail(pend_ff[i]);
               n = n + 4'd1;
            end
         end
         cnt_in = '0;
         exp_in = '0;
         fresh  = 1'b1;
      end

      // byte handled with nothing pending
      if (fresh) begin
         if (b == '0) begin
            // null byte dropped
         end else if (!b[7]) begin
            obuf[n[u8s_pkg::OutIdxW-1:0]] = b;
            n = n + 4'd1;
         end else if ((b >= u8s_pkg::LeadLo) && (b <= u8s_pkg::LeadHi)) begin
            pend_in[0] = b;
            cnt_in     = 2'd1;
            if (b <= u8s_pkg::Lead2Hi) begin
               exp_in = u8s_pkg::Len2;
            end else if (b <= u8s_pkg::Lead3Hi) begin
               exp_in = u8s_pkg::Len3;
            end else begin
               exp_in = u8s_pkg::Len4;
            end
         end else begin
            obuf[n[u8s_pkg::OutIdxW-1:0]] = u8s_pkg::latin1_lead(b);
            n = n + 4'd1;
            obuf[n[u8s_pkg::OutIdxW-1:0]] = u8s_pkg::latin1_tail(b);
            n = n + 4'd1;
         end
      end

      // end of stream flushes whatever is still held
      if (req_if.end_of_stream) begin
         for (int i = 0; i < u8s_pkg::PendDepth; i++) begin
            if (u8s_pkg::PendW'(i) < cnt_in) begin
               obuf[n[u8s_pkg::OutIdxW-1:0]] = u8s_pkg::latin1_lead(pend_in[i]);
               n = n + 4'd1;
               obuf[n[u8s_pkg::OutIdxW-1:0]] = u8s_pkg::latin1_tail(pend_in[i]);
               n = n + 4'd1;
            end
         end
         cnt_in = '0;
         exp_in = '0;
      end
   end

   assign push                 = xfer && (n != '0);
   assign push_entry.out_bytes = obuf;
   assign push_entry.count     = n;

   // pending sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         exp_ff <= '0;
      end else if (xfer) begin
         cnt_ff <= cnt_in;
         exp_ff <= exp_in;
      end
   end

   // held bytes
   always_ff @(posedge clock) begin
      if (xfer) begin
         pend_ff <= pend_in;
      end
   end

endmodule

### src/u8s_queue.sv
// short queue of output runs between front and back
module u8s_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8s_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output u8s_pkg::entry_type pop_entry
);

   u8s_pkg::entry_type             mem_ff [u8s_pkg::QueueDepth];
   logic [u8s_pkg::QPtrW-1:0]      wr_ff, rd_ff;
   logic [u8s_pkg::QCntW-1:0]      cnt_ff, cnt_in;

   assign full      = (cnt_ff == u8s_pkg::QCntW'(u8s_pkg::QueueDepth));
   assign pop_valid = (cnt_ff != '0);
   assign pop_entry = mem_ff[rd_ff];

   // occupancy follows push and pop
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 3'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 3'd1;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 2'd1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 2'd1;
         end
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

### src/u8s_back.sv
// back end: sends each run one byte per cycle, while rsp_if is ready, through an output register
module u8s_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  u8s_pkg::entry_type pop_entry,
   output logic               pop,
   u8s_rsp_if.source          rsp_if
);

   u8s_pkg::entry_type            cur_ff, cur_in;
   logic                          have_ff, have_in;
   logic [u8s_pkg::OutIdxW-1:0]   idx_ff, idx_in;
   logic                          ov_ff, ov_in;
   logic [u8s_pkg::ByteW-1:0]     ob_ff, ob_in;
   logic                          ol_ff, ol_in;
   logic                          load_out;
   logic                          is_last;
   logic                          cur_done;

   // byte selection and run handover
   always_comb begin
      load_out = have_ff && (!ov_ff || rsp_if.ready);
      is_last  = (({1'b0, idx_ff} + 4'd1) == cur_ff.count);
      cur_done = load_out && is_last;
      pop      = pop_valid && (!have_ff || cur_done);

      cur_in  = cur_ff;
      have_in = have_ff;
      idx_in  = idx_ff;
      if (pop) begin
         cur_in  = pop_entry;
         have_in = 1'b1;
         idx_in  = '0;
      end else if (cur_done) begin
         have_in = 1'b0;
      end else if (load_out) begin
         idx_in = idx_ff + 3'd1;
      end

      ov_in = ov_ff;
      ob_in = ob_ff;
      ol_in = ol_ff;
      if (load_out) begin
         ov_in = 1'b1;
         ob_in = cur_ff.out_bytes[idx_ff];
         ol_in = is_last;
      end else if (rsp_if.ready) begin
         ov_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         ov_ff   <= 1'b0;
         idx_ff  <= '0;
      end else begin
         have_ff <= have_in;
         ov_ff   <= ov_in;
         idx_ff  <= idx_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      ob_ff  <= ob_in;
      ol_ff  <= ol_in;
   end

   assign rsp_if.valid       = ov_ff;
   assign rsp_if.out_byte    = ob_ff;
   assign rsp_if.last_of_run = ol_ff;

endmodule

### src/utf8_sanitizer_latin1_fallback.sv
// top level of the utf-8 sanitizer with latin-1 fallback
//
//   channel  dir  handshake     payload
//   req_if   in   valid/ready   data_byte[7:0], end_of_stream
//   rsp_if   out  valid/ready   out_byte[7:0], last_of_run
//
// one input byte is taken per cycle while the four-entry run queue has room.
// each accepted byte yields 0 to 8 output bytes, sent at one byte per cycle by
// the back end while rsp_if is ready; that serializer sets the rate when bytes
// expand (latin-1, flush). the first output byte passes the queue, the run
// register and the output register before it is offered on rsp_if.
// reset is synchronous and empties the pending sequence, queue and output register.
// a stalled rsp_if holds its byte; the front keeps going until the queue fills.
module utf8_sanitizer_latin1_fallback (
   input  logic      clock,
   input  logic      reset,
   u8s_req_if.sink   req_if,
   u8s_rsp_if.source rsp_if
);

   logic               push;
   logic               q_full;
   logic               pop;
   logic               pop_valid;
   u8s_pkg::entry_type push_entry;
   u8s_pkg::entry_type pop_entry;

   // classify and expand
   u8s_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   u8s_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   // serialize runs
   u8s_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

### src/u8s_checker.sv
// port-level checks of the sanitizer, bound to the top level
`include "utf8_sanitizer_latin1_fallback_assert.svh"

module u8s_checker (
   input  logic      clock,
   input  logic      reset,
   u8s_req_if.sink   req_if,
   u8s_rsp_if.source rsp_if
);

   // a stalled output byte holds
   `U8S_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_if.valid && !rsp_if.ready, rsp_if.valid && $stable(rsp_if.out_byte) && $stable(rsp_if.last_of_run))

   // reset leaves nothing to send
   `U8S_ASSERT_NEXT(a_rsp_idle_after_reset, clock, 1'b0, reset, !rsp_if.valid)

   // reset leaves the queue empty so input is taken
   `U8S_ASSERT_NEXT(a_req_ready_after_reset, clock, 1'b0, reset, req_if.ready)

   // null bytes never reach the output
   `U8S_ASSERT_IMPLY(a_no_null_out, clock, reset, rsp_if.valid, rsp_if.out_byte != 8'h00)

endmodule

bind utf8_sanitizer_latin1_fallback u8s_checker u_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);
